### design/lsi_pkg.sv
// Package for the Laplace symbol interval block: field widths, constants and
// the structs passed between the divider cells, the decay unit and the top level.
// No dependencies.
`default_nettype none

package lsi_pkg;

    localparam int SYM_W       = 9;
    localparam int DECAY_W     = 14;
    localparam int LOW_W       = 31;
    localparam int SIZE_W      = 16;
    localparam int TOTAL_W     = 31;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 80;
    localparam int DIVISOR_W   = 15;
    localparam int REM_W       = 15;
    localparam int QUO_W       = 31;
    localparam int ACC_W       = 32;
    localparam int FRAC_BITS   = 14;

    localparam int DEFAULT_MAX_MAGNITUDE = 255;

    localparam logic [DIVISOR_W-1:0] ONE_Q14    = 15'd16384;
    localparam logic [SIZE_W-1:0]    HALF_RANGE = 16'd32768;
    localparam logic [QUO_W-1:0]     DIVIDEND   = 31'h4000_0000;

    typedef struct packed {
        logic                 valid;
        logic [REM_W-1:0]     rem;
        logic [QUO_W-1:0]     quo;
        logic [DIVISOR_W-1:0] divisor;
    } lsi_div_t;

    typedef struct packed {
        logic               neg;
        logic [SYM_W-1:0]   mag;
        logic [DECAY_W-1:0] decay;
    } lsi_job_t;

    typedef struct packed {
        logic              done;
        logic [LOW_W-1:0]  cum_low;
        logic [SIZE_W-1:0] interval_size;
    } lsi_loop_res_t;

endpackage

`default_nettype wire

### design/lsi_div_cell.sv
// One cell of the divider chain: a single restoring division step per cycle.
// Depends on lsi_pkg.
`default_nettype none

module lsi_div_cell
    import lsi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     dividend_bit,
    input  wire lsi_div_t prev,
    output lsi_div_t      next
);

    logic                 valid_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] divisor_reg;

    logic [REM_W:0]   trial;
    logic             fits;
    logic [REM_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_next;

    always_comb
    begin
        trial    = {prev.rem, dividend_bit};
        fits     = trial >= {1'b0, prev.divisor};
        rem_next = fits ? REM_W'(trial - {1'b0, prev.divisor}) : REM_W'(trial);
        quo_next = {prev.quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= prev.divisor;
    end

    assign next.valid   = valid_reg;
    assign next.rem     = rem_reg;
    assign next.quo     = quo_reg;
    assign next.divisor = divisor_reg;

endmodule

`default_nettype wire

### design/lsi_decay_unit.sv
// Decay loop: one multiply-shift step of the interval width per unit of
// magnitude, then clipping and the sign correction. Depends on lsi_pkg.
`default_nettype none

module lsi_decay_unit
    import lsi_pkg::*;
#(
    parameter int MAX_MAGNITUDE = DEFAULT_MAX_MAGNITUDE
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire lsi_job_t job,
    output lsi_loop_res_t res
);

    localparam int CNT_W = $clog2(MAX_MAGNITUDE + 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] low_reg, low_next;
    logic [SIZE_W-1:0]       width_reg, width_next;
    logic [DECAY_W-1:0]      decay_reg, decay_next;
    logic                    neg_reg, neg_next;

    logic [SIZE_W+DECAY_W-1:0] prod;
    logic signed [ACC_W-1:0]   low_clip;
    logic [CNT_W-1:0]          mag_sat;

    assign prod     = (SIZE_W+DECAY_W)'(width_reg) * (SIZE_W+DECAY_W)'(decay_reg);
    assign low_clip = low_reg[ACC_W-1] ? '0 : low_reg;
    assign mag_sat  = (32'(job.mag) > 32'(MAX_MAGNITUDE)) ? CNT_W'(MAX_MAGNITUDE)
                                                          : CNT_W'(job.mag);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        low_next   = low_reg;
        width_next = width_reg;
        decay_next = decay_reg;
        neg_next   = neg_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            cnt_next   = mag_sat;
            low_next   = -$signed(ACC_W'(HALF_RANGE));
            width_next = HALF_RANGE;
            decay_next = job.decay;
            neg_next   = job.neg;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                low_next   = low_reg + $signed(ACC_W'({width_reg, 1'b0}));
                width_next = prod[FRAC_BITS +: SIZE_W];
                cnt_next   = cnt_reg - CNT_W'(1);
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                low_next  = neg_reg ? low_clip + $signed(ACC_W'(width_reg)) : low_clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        low_reg   <= low_next;
        width_reg <= width_next;
        decay_reg <= decay_next;
        neg_reg   <= neg_next;
    end

    assign res.done          = done_reg;
    assign res.cum_low       = LOW_W'(low_reg);
    assign res.interval_size = width_reg;

endmodule

`default_nettype wire

### design/laplace_symbol_interval.sv
// A result needs both the total from the divider chain of 31 cells and the
// interval from the multiply-shift loop, one step per unit of magnitude.
// One item is in work at a time: the next is taken only once the last result
// is in the output register. The finished result sits there until taken.
// Reset (rst_n, asynchronous, active low) empties the chain and the output.
// Top level; depends on lsi_pkg, lsi_div_cell and lsi_decay_unit.
`default_nettype none

module laplace_symbol_interval
    import lsi_pkg::*;
#(
    parameter int MAX_MAGNITUDE = DEFAULT_MAX_MAGNITUDE
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // symbol_value [8:0], decay_q14 [22:9], zero [23]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // cum_low [30:0], interval_size [46:31], freq_total [77:47], zero [79:78]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic                   total_valid_reg, total_valid_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                   accept;
    logic                   finish;
    logic [SYM_W-1:0]       sym;
    logic [DECAY_W-1:0]     decay;
    lsi_job_t               job;
    lsi_loop_res_t          loop_res;
    lsi_div_t               chain [0:QUO_W];

    assign sym      = s_tdata[SYM_W-1:0];
    assign decay    = s_tdata[SYM_W +: DECAY_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign job.neg   = sym[SYM_W-1];
    assign job.mag   = sym[SYM_W-1] ? SYM_W'(-sym) : sym;
    assign job.decay = decay;

    assign chain[0].valid   = accept;
    assign chain[0].rem     = '0;
    assign chain[0].quo     = '0;
    assign chain[0].divisor = ONE_Q14 - DIVISOR_W'(decay);

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        lsi_div_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .dividend_bit (DIVIDEND[QUO_W-1-i]),
            .prev         (chain[i]),
            .next         (chain[i+1])
        );
    end

    lsi_decay_unit #(
        .MAX_MAGNITUDE (MAX_MAGNITUDE)
    ) u_decay (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .job   (job),
        .res   (loop_res)
    );

    assign finish = (state_reg == ST_BUSY) && loop_res.done && total_valid_reg
                    && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next       = state_reg;
        total_valid_next = total_valid_reg;
        total_next       = total_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (chain[QUO_W].valid)
        begin
            total_valid_next = 1'b1;
            total_next       = chain[QUO_W].quo - TOTAL_W'(HALF_RANGE) + TOTAL_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    total_valid_next = 1'b0;
                    state_next       = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (finish)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, total_reg, loop_res.interval_size,
                                     loop_res.cum_low};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            total_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            total_valid_reg <= total_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### design/lsi_checker.sv
// Port-level checks for laplace_symbol_interval, attached by the bind below.
// Depends on lsi_pkg and the top level.
`default_nettype none

module lsi_checker
    import lsi_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result item dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("Result item changed while stalled.");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input taken while an item is in work.");

    a_total_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[LOW_W+SIZE_W +: TOTAL_W] > TOTAL_W'(HALF_RANGE))
        else $error("Total frequency below its floor.");

    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[LOW_W +: SIZE_W] <= HALF_RANGE)
        else $error("Interval size above its start value.");

endmodule

bind laplace_symbol_interval lsi_checker u_lsi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### bench/tb.sv
// Testbench for laplace_symbol_interval: drives symbol and decay items, predicts each
// interval and total independently, and checks every result field by field.
// Depends on lsi_pkg and the laplace_symbol_interval RTL.
`timescale 1ns / 100ps

module tb;
    import lsi_pkg::*;

    localparam int MAG_LIMIT = DEFAULT_MAX_MAGNITUDE;

    typedef struct {
        logic [LOW_W-1:0]   cum_low;
        logic [SIZE_W-1:0]  interval_size;
        logic [TOTAL_W-1:0] freq_total;
    } interval_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    interval_t pending_intervals[$];
    bit        no_idle = 1'b0;
    int        items_sent = 0;
    int        results_checked = 0;
    int        mismatches = 0;
    int        zero_width_seen = 0;
    int        saturated_sent = 0;

    laplace_symbol_interval u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic interval_t laplace_interval(logic [SYM_W-1:0] sym,
                                                   logic [DECAY_W-1:0] decay);
        interval_t          res;
        logic               neg;
        int unsigned        mag;
        longint             low;
        longint unsigned    width;
        longint unsigned    total;
        neg   = sym[SYM_W-1];
        mag   = neg ? (512 - int'(sym)) : int'(sym);
        low   = -32768;
        width = 32768;
        total = (64'd1 << 30) / (64'd16384 - 64'(decay)) - 64'd32768 + 64'd1;
        if (mag > MAG_LIMIT)
        begin
            mag = MAG_LIMIT;
        end
        for (int i = 0; i < mag; i++)
        begin
            low   = low + longint'(width * 2);
            width = (width * 64'(decay)) >> 14;
        end
        if (low < 0)
        begin
            low = 0;
        end
        if (neg)
        begin
            low = low + longint'(width);
        end
        res.cum_low       = low[LOW_W-1:0];
        res.interval_size = width[SIZE_W-1:0];
        res.freq_total    = total[TOTAL_W-1:0];
        return res;
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(logic [SYM_W-1:0] sym, logic [DECAY_W-1:0] decay);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, decay, sym};
        do
            @(posedge clk);
        while (!s_tready);
        pending_intervals.push_back(laplace_interval(sym, decay));
        items_sent++;
        if (sym == 9'h100)
        begin
            saturated_sent++;
        end
    endtask

    task automatic test_field_extremes();
        send_item(9'sd0, 14'd0);
        send_item(9'sd0, 14'd16383);
        send_item(9'sd1, 14'd16383);
        send_item(-9'sd1, 14'd16383);
        send_item(9'sd255, 14'd16383);
        send_item(-9'sd255, 14'd16383);
        send_item(9'sd255, 14'd1);
        send_item(-9'sd255, 14'd8192);
        send_item(9'sd2, 14'd10922);
        send_item(-9'sd3, 14'h2AAA);
        send_item(9'sd170, 14'h1555);
    endtask

    task automatic test_special_cases();
        // Magnitude beyond the limit is saturated, sign kept.
        send_item(-9'sd256, 14'd16383);
        send_item(-9'sd256, 14'd0);
        send_item(-9'sd256, 14'd12000);
        // Width decays to zero part way through the loop.
        send_item(9'sd255, 14'd1000);
        send_item(-9'sd40, 14'd4000);
        send_item(9'sd16, 14'd100);
        // Zero decay: every nonzero magnitude leaves no width.
        send_item(9'sd1, 14'd0);
        send_item(-9'sd1, 14'd0);
        send_item(9'sd7, 14'd0);
        send_item(-9'sd100, 14'd0);
    endtask

    task automatic test_random_symbols(int count);
        logic [SYM_W-1:0]   sym;
        logic [DECAY_W-1:0] decay;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            sym = SYM_W'($urandom_range(0, 511));
            case ($urandom_range(0, 7))
                0:       decay = 14'd0;
                1:       decay = 14'd16383;
                2, 3:    decay = DECAY_W'($urandom_range(15000, 16383));
                default: decay = DECAY_W'($urandom_range(0, 16383));
            endcase
            send_item(sym, decay);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        interval_t want;
        interval_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cum_low       = m_tdata[30:0];
            got.interval_size = m_tdata[46:31];
            got.freq_total    = m_tdata[77:47];
            if (pending_intervals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result: cum_low=%0d size=%0d total=%0d",
                             got.cum_low, got.interval_size, got.freq_total);
                end
            end
            else
            begin
                want = pending_intervals.pop_front();
                results_checked++;
                if (got.interval_size == '0)
                begin
                    zero_width_seen++;
                end
                if (got.cum_low !== want.cum_low || got.interval_size !== want.interval_size
                    || got.freq_total !== want.freq_total || m_tdata[79:78] !== 2'b00)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch on result %0d: expected low=%0d size=%0d total=%0d,",
                                 results_checked, want.cum_low, want.interval_size,
                                 want.freq_total);
                        $display("    got low=%0d size=%0d total=%0d pad=%b",
                                 got.cum_low, got.interval_size, got.freq_total,
                                 m_tdata[79:78]);
                    end
                end
            end
        end
    end

    initial
    begin
        int stall;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        #15ms;
        $display("Timeout with %0d results outstanding", pending_intervals.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_special_cases();
        test_random_symbols(1000);
        s_tvalid <= 1'b0;
        while (pending_intervals.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        $display("Sent %0d items (%0d saturated), checked %0d results, %0d with zero width.",
                 items_sent, saturated_sent, results_checked, zero_width_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_intervals.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
